// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files; the job queue includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define EBC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define EBC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   `EBC_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/ebc_pkg.sv =====
// Package: widths, job types and easing weight tables of the cursor path block.
`default_nettype none

package ebc_pkg;

   localparam int STEPS      = 30;
   localparam int STEP_W     = $clog2(STEPS);

   localparam int COORD_W    = 14;
   localparam int DELTA_W    = COORD_W + 1;
   localparam int GAIN_W     = 8;
   localparam int GE_W       = DELTA_W + GAIN_W + 1;
   localparam int WA_W       = 21;
   localparam int WB_W       = 20;
   localparam int P_W        = DELTA_W + WA_W + 1;
   localparam int Q_W        = GE_W + WB_W + 1;
   localparam int DA_SHIFT   = 12;
   localparam int GE_SHIFT   = 4;
   localparam int FRAC_SHIFT = 28;
   localparam int SUM_W      = P_W + DA_SHIFT + 1;
   localparam int R_W        = SUM_W - FRAC_SHIFT;
   localparam int SUB_BITS   = 4;
   localparam int V_W        = R_W + 1;
   localparam int POINT_W    = 20;

   localparam logic signed [V_W-1:0] OUT_LOW  = -V_W'(65536);
   localparam logic signed [V_W-1:0] OUT_HIGH = V_W'(393215);
   localparam logic [SUM_W-1:0] ROUND_HALF    = SUM_W'(1) << (FRAC_SHIFT - 1);

   localparam logic [COORD_W-1:0] CURSOR_RESET = COORD_W'(40);
   localparam logic [GAIN_W-1:0]  GAIN_RESET   = GAIN_W'(41);

   // CSR map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_CURVE_GAIN = '0;

   // Job queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [COORD_W-1:0]        sx;
      logic [COORD_W-1:0]        sy;
      logic [COORD_W-1:0]        tx;
      logic [COORD_W-1:0]        ty;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic signed [GE_W-1:0]    gex;   // gain * -dy
      logic signed [GE_W-1:0]    gey;   // gain * dx
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } job_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Easing weights, Q20, per step index k = i - 1
   localparam longint unsigned DSQ    = 64'(STEPS) * 64'(STEPS);
   localparam longint unsigned DCUBE  = DSQ * DSQ * DSQ;
   localparam longint unsigned WA_DEN = 64'd100 * DCUBE;
   localparam longint unsigned WB_DEN = DSQ * DSQ;

   typedef logic [WA_W-1:0] wa_table_type [STEPS];
   typedef logic [WB_W-1:0] wb_table_type [STEPS];

   function automatic longint unsigned eased_u(input int k);
      longint unsigned ii;
      longint unsigned nn;
      ii = 64'(k + 1);
      nn = 64'(STEPS);
      if (2 * ii < nn) begin
         return 2 * ii * ii;
      end
      return DSQ - 2 * (nn - ii) * (nn - ii);
   endfunction

   function automatic wa_table_type build_wa_table();
      wa_table_type    tbl;
      longint unsigned uu;
      longint unsigned mm;
      longint unsigned a;
      longint unsigned w;
      for (int k = 0; k < STEPS; k++) begin
         uu = eased_u(k);
         mm = DSQ - uu;
         a  = 99 * mm * mm * uu + 198 * mm * uu * uu + 100 * uu * uu * uu;
         w  = ((a << 20) + WA_DEN / 2) / WA_DEN;
         tbl[k] = w[WA_W-1:0];
      end
      return tbl;
   endfunction

   function automatic wb_table_type build_wb_table();
      wb_table_type    tbl;
      longint unsigned uu;
      longint unsigned mm;
      longint unsigned w;
      for (int k = 0; k < STEPS; k++) begin
         uu = eased_u(k);
         mm = DSQ - uu;
         w  = (((3 * mm * uu) << 20) + WB_DEN / 2) / WB_DEN;
         tbl[k] = w[WB_W-1:0];
      end
      return tbl;
   endfunction

   localparam wa_table_type WA_TABLE = build_wa_table();
   localparam wb_table_type WB_TABLE = build_wb_table();

endpackage

`default_nettype wire

// ===== hw/rtl/ebc_channels.sv =====
// Valid/ready channel interfaces for targets and path points.
`default_nettype none

interface ebc_req_if;
   import ebc_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] target_x;
   logic [COORD_W-1:0] target_y;

   modport source (output valid, output target_x, output target_y, input ready);
   modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface ebc_rsp_if;
   import ebc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;
   logic                      last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input last_point,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ebc_front.sv =====
// Front end: takes targets, tracks the cursor, builds jobs for the queue.
`default_nettype none

module ebc_front (
   input  logic                          clock,
   input  logic                          reset,
   ebc_req_if.sink                       req_if,
   input  logic [ebc_pkg::GAIN_W-1:0]    curve_gain,
   input  ebc_pkg::queue_status_type     queue_status,
   output ebc_pkg::job_push_type         job_push
);
   import ebc_pkg::*;

   logic [COORD_W-1:0]        cursor_x_ff, cursor_x_in;
   logic [COORD_W-1:0]        cursor_y_ff, cursor_y_in;
   logic                      accept;
   logic signed [DELTA_W-1:0] dx;
   logic signed [DELTA_W-1:0] dy;
   logic signed [DELTA_W-1:0] neg_dy;
   logic signed [GAIN_W:0]    gain_s;

   assign req_if.ready = !queue_status.full;
   assign accept       = req_if.valid && req_if.ready;

   assign dx     = $signed({1'b0, req_if.target_x}) - $signed({1'b0, cursor_x_ff});
   assign dy     = $signed({1'b0, req_if.target_y}) - $signed({1'b0, cursor_y_ff});
   assign neg_dy = -dy;
   assign gain_s = $signed({1'b0, curve_gain});

   always_comb begin
      job_push.push    = accept;
      job_push.job.sx  = cursor_x_ff;
      job_push.job.sy  = cursor_y_ff;
      job_push.job.tx  = req_if.target_x;
      job_push.job.ty  = req_if.target_y;
      job_push.job.dx  = dx;
      job_push.job.dy  = dy;
      job_push.job.gex = gain_s * neg_dy;
      job_push.job.gey = gain_s * dx;
   end

   // the target becomes the start of the next path
   assign cursor_x_in = accept ? req_if.target_x : cursor_x_ff;
   assign cursor_y_in = accept ? req_if.target_y : cursor_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= CURSOR_RESET;
         cursor_y_ff <= CURSOR_RESET;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ebc_job_queue.sv =====
// Short job queue between front end and point generator.
`default_nettype none

`include "assert_macros.svh"

module ebc_job_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  ebc_pkg::job_push_type      push_in,
   input  logic                       pop,
   output ebc_pkg::job_type           head,
   output ebc_pkg::queue_status_type  status
);
   import ebc_pkg::*;

   job_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push_in.push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push_in.push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entries_ff[wr_ptr_ff] <= push_in.job;
      end
   end

   `EBC_ASSERT_IMPLY(a_no_push_full, clock, reset, push_in.push, count_ff != QCNT_W'(QUEUE_DEPTH), "job pushed into full queue")
   `EBC_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, count_ff != '0, "job popped from empty queue")
   `EBC_ASSERT_IMPLY(a_ptr_count, clock, reset, count_ff != QCNT_W'(QUEUE_DEPTH), QCNT_W'(QPTR_W'(wr_ptr_ff - rd_ptr_ff)) == count_ff, "queue pointers disagree with count")

endmodule

`default_nettype wire

// ===== hw/rtl/ebc_back.sv =====
// Back end: steps through each job and computes the eased Bezier points.
`default_nettype none

module ebc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ebc_pkg::job_type           head,
   input  ebc_pkg::queue_status_type  queue_status,
   output logic                       pop,
   ebc_rsp_if.source                  rsp_if
);
   import ebc_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

   logic                enable;
   logic                issue;
   logic                issue_last;
   logic [STEP_W-1:0]   step_ff, step_in;

   // stage 0: job and table weights
   logic                s0_valid_ff;
   logic                s0_last_ff;
   job_type             s0_job_ff;
   logic [WA_W-1:0]     s0_wa_ff;
   logic [WB_W-1:0]     s0_wb_ff;

   // stage 1: products
   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic [COORD_W-1:0]     s1_sx_ff, s1_sy_ff, s1_tx_ff, s1_ty_ff;
   logic signed [P_W-1:0]  s1_px_ff, s1_py_ff;
   logic signed [Q_W-1:0]  s1_qx_ff, s1_qy_ff;

   // stage 2: output register
   logic                      s2_valid_ff;
   logic                      s2_last_ff;
   logic signed [POINT_W-1:0] s2_x_ff, s2_x_in;
   logic signed [POINT_W-1:0] s2_y_ff, s2_y_in;

   function automatic logic signed [POINT_W-1:0] make_point(
      input logic signed [P_W-1:0] p,
      input logic signed [Q_W-1:0] q,
      input logic [COORD_W-1:0]    s
   );
      logic signed [SUM_W-1:0] sum;
      logic signed [R_W-1:0]   r;
      logic signed [V_W-1:0]   v;
      sum = $signed({p[P_W-1], p, DA_SHIFT'(0)})
          + $signed({{(SUM_W-Q_W-GE_SHIFT){q[Q_W-1]}}, q, GE_SHIFT'(0)})
          + $signed(ROUND_HALF);
      r = sum[SUM_W-1:FRAC_SHIFT];
      v = $signed({{(V_W-R_W){r[R_W-1]}}, r})
        + $signed({{(V_W-COORD_W-SUB_BITS){1'b0}}, s, SUB_BITS'(0)});
      if (v < OUT_LOW) begin
         v = OUT_LOW;
      end else if (v > OUT_HIGH) begin
         v = OUT_HIGH;
      end
      return v[POINT_W-1:0];
   endfunction

   // whole pipeline moves when the output register can take a point
   assign enable     = !s2_valid_ff || rsp_if.ready;
   assign issue      = enable && !queue_status.empty;
   assign issue_last = (step_ff == LAST_STEP);
   assign pop        = issue && issue_last;

   always_comb begin
      step_in = step_ff;
      if (issue) begin
         step_in = issue_last ? '0 : step_ff + 1'b1;
      end
   end

   always_comb begin
      if (s1_last_ff) begin
         s2_x_in = $signed({{(POINT_W-COORD_W-SUB_BITS){1'b0}}, s1_tx_ff, SUB_BITS'(0)});
         s2_y_in = $signed({{(POINT_W-COORD_W-SUB_BITS){1'b0}}, s1_ty_ff, SUB_BITS'(0)});
      end else begin
         s2_x_in = make_point(s1_px_ff, s1_qx_ff, s1_sx_ff);
         s2_y_in = make_point(s1_py_ff, s1_qy_ff, s1_sy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (enable) begin
            s0_valid_ff <= issue;
            s1_valid_ff <= s0_valid_ff;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_last_ff <= issue_last;
         s0_job_ff  <= head;
         s0_wa_ff   <= WA_TABLE[step_ff];
         s0_wb_ff   <= WB_TABLE[step_ff];

         s1_last_ff <= s0_last_ff;
         s1_sx_ff   <= s0_job_ff.sx;
         s1_sy_ff   <= s0_job_ff.sy;
         s1_tx_ff   <= s0_job_ff.tx;
         s1_ty_ff   <= s0_job_ff.ty;
         s1_px_ff   <= s0_job_ff.dx * $signed({1'b0, s0_wa_ff});
         s1_py_ff   <= s0_job_ff.dy * $signed({1'b0, s0_wa_ff});
         s1_qx_ff   <= s0_job_ff.gex * $signed({1'b0, s0_wb_ff});
         s1_qy_ff   <= s0_job_ff.gey * $signed({1'b0, s0_wb_ff});

         s2_last_ff <= s1_last_ff;
         s2_x_ff    <= s2_x_in;
         s2_y_ff    <= s2_y_in;
      end
   end

   assign rsp_if.valid      = s2_valid_ff;
   assign rsp_if.point_x    = s2_x_ff;
   assign rsp_if.point_y    = s2_y_ff;
   assign rsp_if.last_point = s2_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/eased_bezier_cursor_path.sv =====
// Top level: cursor glide along an eased cubic Bezier path, with CSR port.
// Each accepted target yields STEPS (30) points, one point per cycle while the
// output takes points; the step counter in the back end sets the sustained rate.
// Targets stream back to back: the front end takes a new target whenever the
// two-entry job queue has room, and the back end goes on to the next queued job
// after the last step of the current one. On an idle block the first point of a
// path passes the queue write, the table read, the multiply, and the sum and
// round into the output register. Points are in 1/16
// pixel; the last one of a path carries last_point and equals the target, which
// becomes the start of the next path. Cursor resets to (40,40), curve_gain to 41.
// curve_gain sits at byte address 0 and may be written only while no path is
// in flight; the APB port never waits.
`default_nettype none

module eased_bezier_cursor_path (
   input  logic                              clock,
   input  logic                              reset,
   ebc_req_if.sink                           req_if,
   ebc_rsp_if.source                         rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ebc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ebc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ebc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import ebc_pkg::*;

   logic [GAIN_W-1:0]  curve_gain_ff, curve_gain_in;
   logic               csr_write;
   logic               csr_hit;
   job_push_type       job_push;
   job_type            job_head;
   queue_status_type   queue_status;
   logic               job_pop;

   // ---- CSR: single register, zero wait states ----
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == REG_CURVE_GAIN);
   assign csr_write = psel && penable && pwrite && pready;

   // writes to other addresses are dropped
   assign curve_gain_in = (csr_write && csr_hit) ? pwdata[GAIN_W-1:0] : curve_gain_ff;
   assign prdata        = csr_hit ? {{(CSR_DATA_W-GAIN_W){1'b0}}, curve_gain_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_gain_ff <= GAIN_RESET;
      end else begin
         curve_gain_ff <= curve_gain_in;
      end
   end

   // ---- front end: target transaction -> job (deltas, sideways push) ----
   ebc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .curve_gain   (curve_gain_ff),
      .queue_status (queue_status),
      .job_push     (job_push)
   );

   // ---- decoupling queue ----
   ebc_job_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (job_push),
      .pop     (job_pop),
      .head    (job_head),
      .status  (queue_status)
   );

   // ---- back end: STEPS point transactions per job ----
   ebc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (job_head),
      .queue_status (queue_status),
      .pop          (job_pop),
      .rsp_if       (rsp_if)
   );

endmodule

`default_nettype wire

// ===== test/eased_bezier_cursor_path_checker.sv =====
// Checker for the cursor path block: predicts each eased Bezier path and compares every point.
module ebc_path_checker
   import ebc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ebc_req_if                    req_mon,
   ebc_rsp_if                    rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   output int                    mismatches,
   output int                    pending_points,
   output int                    targets_seen,
   output int                    points_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [POINT_W-1:0] x;
      logic signed [POINT_W-1:0] y;
      logic                      last;
   } path_point_type;

   localparam logic [CSR_ADDR_W-1:0] GAIN_ADDR = {REG_CURVE_GAIN, 2'b00};
   localparam longint FRAC_HALF  = 64'sd134217728;   // half of 2^28
   localparam longint CLAMP_LOW  = -64'sd65536;
   localparam longint CLAMP_HIGH = 64'sd393215;

   longint             line_weight [STEPS];   // Q20 weight of the straight delta
   longint             bow_weight  [STEPS];   // Q20 weight of the sideways push
   logic [GAIN_W-1:0]  gain;
   logic [COORD_W-1:0] cur_x;
   logic [COORD_W-1:0] cur_y;
   path_point_type     expected_points [$];

   // eased parameter u = U / STEPS^2, exact
   initial begin : build_weights
      longint unsigned d_sq;
      longint unsigned d_cube;
      longint unsigned u;
      longint unsigned m;
      longint unsigned acc;
      d_sq   = 64'(STEPS) * 64'(STEPS);
      d_cube = d_sq * d_sq * d_sq;
      for (int i = 1; i <= STEPS; i++) begin
         u = (2 * i < STEPS) ? 64'(2 * i * i) : d_sq - 64'(2 * (STEPS - i) * (STEPS - i));
         m = d_sq - u;
         acc = 99 * m * m * u + 198 * m * u * u + 100 * u * u * u;
         line_weight[i-1] = ((acc << 20) + 50 * d_cube) / (100 * d_cube);
         bow_weight[i-1]  = (((3 * m * u) << 20) + d_sq * d_sq / 2) / (d_sq * d_sq);
      end
   end

   function automatic longint glide_coord(input longint start, input longint delta,
                                          input longint push, input longint wa,
                                          input longint wb, input longint g);
      longint num;
      longint v;
      num = 4096 * delta * wa + 16 * g * push * wb;
      v = 16 * start + ((num + FRAC_HALF) >>> 28);
      if (v < CLAMP_LOW) v = CLAMP_LOW;
      if (v > CLAMP_HIGH) v = CLAMP_HIGH;
      return v;
   endfunction

   function automatic void predict_path(input logic [COORD_W-1:0] tx,
                                        input logic [COORD_W-1:0] ty);
      longint         sx;
      longint         sy;
      longint         tx_l;
      longint         ty_l;
      longint         dx;
      longint         dy;
      longint         g;
      path_point_type p;
      sx = cur_x;
      sy = cur_y;
      tx_l = tx;
      ty_l = ty;
      dx = tx_l - sx;
      dy = ty_l - sy;
      g = gain;
      for (int i = 1; i <= STEPS; i++) begin
         if (i == STEPS) begin
            p.x = POINT_W'(16 * tx_l);
            p.y = POINT_W'(16 * ty_l);
            p.last = 1'b1;
         end else begin
            p.x = POINT_W'(glide_coord(sx, dx, -dy, line_weight[i-1], bow_weight[i-1], g));
            p.y = POINT_W'(glide_coord(sy, dy, dx, line_weight[i-1], bow_weight[i-1], g));
            p.last = 1'b0;
         end
         expected_points.push_back(p);
      end
      cur_x = tx;
      cur_y = ty;
   endfunction

   always @(posedge clock) begin : monitor
      path_point_type want;
      if (reset) begin
         gain = GAIN_RESET;
         cur_x = CURSOR_RESET;
         cur_y = CURSOR_RESET;
         expected_points.delete();
      end else begin
         // csr traffic: writes to unmapped addresses are dropped
         if (psel && penable && pready) begin
            if (pwrite && paddr == GAIN_ADDR) begin
               gain = pwdata[GAIN_W-1:0];
            end else if (!pwrite && paddr == GAIN_ADDR && prdata !== CSR_DATA_W'(gain)) begin
               $display("%0t: curve_gain read mismatch, expected %0d actual %0d",
                        $time, gain, prdata);
               mismatches++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_path(req_mon.target_x, req_mon.target_y);
            targets_seen++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected point transaction, expected none actual x %0d y %0d",
                        $time, rsp_mon.point_x, rsp_mon.point_y);
               mismatches++;
            end else begin
               want = expected_points.pop_front();
               points_checked++;
               if (rsp_mon.point_x !== want.x) begin
                  $display("%0t: point_x mismatch, expected %0d actual %0d",
                           $time, want.x, rsp_mon.point_x);
                  mismatches++;
               end
               if (rsp_mon.point_y !== want.y) begin
                  $display("%0t: point_y mismatch, expected %0d actual %0d",
                           $time, want.y, rsp_mon.point_y);
                  mismatches++;
               end
               if (rsp_mon.last_point !== want.last) begin
                  $display("%0t: last_point mismatch, expected %0d actual %0d",
                           $time, want.last, rsp_mon.last_point);
                  mismatches++;
               end
            end
         end
      end
      pending_points <= expected_points.size();
   end

endmodule

// ===== test/eased_bezier_cursor_path_tb.sv =====
// Testbench top: drives targets, csr traffic and point back-pressure, and reports the verdict.
module eased_bezier_cursor_path_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ebc_pkg::*;

   localparam int TARGET_MAX = (1 << COORD_W) - 1;
   localparam logic [CSR_ADDR_W-1:0] GAIN_ADDR  = {REG_CURVE_GAIN, 2'b00};
   // one word past curve_gain: no register lives there
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = GAIN_ADDR + CSR_ADDR_W'(4);
   // idle margin after the last point, before the next phase
   localparam int SETTLE_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  calm = 1'b0;     // no idling on either side once set
   logic [COORD_W-1:0]    last_x = CURSOR_RESET;
   logic [COORD_W-1:0]    last_y = CURSOR_RESET;
   int                    stall_left = 0;
   int                    run_left = 0;
   int                    mismatches;
   int                    pending_points;
   int                    targets_seen;
   int                    points_checked;

   ebc_req_if req_ch ();
   ebc_rsp_if rsp_ch ();

   eased_bezier_cursor_path dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   ebc_path_checker path_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .mismatches     (mismatches),
      .pending_points (pending_points),
      .targets_seen   (targets_seen),
      .points_checked (points_checked)
   );

   always #4 clock = ~clock;

   // Hard stop: the slowest legal run is well under a tenth of this.
   initial begin : time_limit
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Point-side back-pressure: runs of ready mixed with random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (calm) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
         run_left = run_left - 1;
         rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         run_left = $urandom_range(0, 40);
         rsp_ch.ready <= 1'b1;
      end
   end

   // APB setup cycle, access cycle held until pready, then the bus returns to idle.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write then read back; the checker compares the read data.
   task automatic set_gain(input logic [GAIN_W-1:0] g);
      csr_access(1'b1, GAIN_ADDR, CSR_DATA_W'(g));
      csr_access(1'b0, GAIN_ADDR, '0);
   endtask

   // Hold off new targets until every predicted point has come out.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One target transaction, with an optional random gap in front of it.
   task automatic send_target(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.target_x <= x;
      req_ch.target_y <= y;
      do @(posedge clock); while (!req_ch.ready);
      last_x = x;
      last_y = y;
   endtask

   // Target mix: long jumps, short hops, corners, axis moves and zero moves.
   function automatic void pick_target(output logic [COORD_W-1:0] x,
                                       output logic [COORD_W-1:0] y);
      int vx;
      int vy;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            vx = $urandom_range(0, TARGET_MAX);
            vy = $urandom_range(0, TARGET_MAX);
         end
         4, 5: begin
            vx = int'(last_x) + $urandom_range(0, 128) - 64;
            vy = int'(last_y) + $urandom_range(0, 128) - 64;
         end
         6: begin
            vx = $urandom_range(0, 1) ? TARGET_MAX : 0;
            vy = $urandom_range(0, 1) ? TARGET_MAX : 0;
         end
         7: begin
            vx = last_x;
            vy = last_y;
         end
         8: begin
            vx = last_x;
            vy = $urandom_range(0, TARGET_MAX);
         end
         default: begin
            vx = $urandom_range(0, TARGET_MAX);
            vy = last_y;
         end
      endcase
      if (vx < 0) vx = 0;
      if (vx > TARGET_MAX) vx = TARGET_MAX;
      if (vy < 0) vy = 0;
      if (vy > TARGET_MAX) vy = TARGET_MAX;
      x = COORD_W'(vx);
      y = COORD_W'(vy);
   endfunction

   task automatic random_targets(input int count, input logic [GAIN_W-1:0] g);
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      set_gain(g);
      repeat (count) begin
         pick_target(x, y);
         send_target(x, y);
      end
      drain();
   endtask

   initial begin : stimulus
      req_ch.valid    <= 1'b0;
      req_ch.target_x <= '0;
      req_ch.target_y <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      reset   <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset gain read back, then paths at the default gain
      csr_access(1'b0, GAIN_ADDR, '0);
      send_target(COORD_W'(40), COORD_W'(40));            // zero move from reset cursor
      send_target('0, '0);
      send_target(COORD_W'(TARGET_MAX), COORD_W'(TARGET_MAX));
      send_target('0, COORD_W'(TARGET_MAX));
      send_target(COORD_W'(TARGET_MAX), '0);
      send_target(COORD_W'(TARGET_MAX), '0);               // zero move again
      drain();

      // full gain: long perpendicular pushes drive both coords into saturation
      set_gain(GAIN_W'(255));
      send_target('0, '0);
      send_target('0, COORD_W'(TARGET_MAX));               // x clamps low
      send_target(COORD_W'(TARGET_MAX), COORD_W'(TARGET_MAX)); // y clamps high
      send_target(COORD_W'(TARGET_MAX), '0);               // x clamps high
      send_target('0, '0);                                 // y clamps low
      send_target(COORD_W'(14'h2AAA), COORD_W'(14'h1555));
      send_target(COORD_W'(14'h1555), COORD_W'(14'h2AAA));
      drain();

      // no bow: straight eased lines; unmapped write must not touch the gain
      set_gain('0);
      csr_access(1'b1, SPARE_ADDR, CSR_DATA_W'($urandom));
      csr_access(1'b0, GAIN_ADDR, '0);
      send_target(COORD_W'(100), COORD_W'(9000));
      send_target(COORD_W'(16000), COORD_W'(3));
      drain();

      // random part, several gains
      random_targets(28, GAIN_W'($urandom_range(0, 255)));
      random_targets(28, GAIN_W'(128));
      random_targets(28, GAIN_W'($urandom_range(0, 255)));
      calm <= 1'b1;
      random_targets(28, GAIN_RESET);

      $display("Covered %0d targets and %0d path points at gains 41, 255, 0, 128 and random,",
               targets_seen, points_checked);
      $display("with zero moves, corner jumps, clamped paths, an unmapped write and read-backs.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ebc_pkg.sv
hw/rtl/ebc_channels.sv
hw/rtl/ebc_front.sv
hw/rtl/ebc_job_queue.sv
hw/rtl/ebc_back.sv
hw/rtl/eased_bezier_cursor_path.sv
test/eased_bezier_cursor_path_checker.sv
test/eased_bezier_cursor_path_tb.sv
